@@ src/dcc_pkg.sv @@
// shared types, constants and helper functions of the dna context count model
package dcc_pkg;

   localparam int MAX_DEPTH = 6;
   localparam int COUNT_W = 32;
   localparam int ROWS = 5 ** MAX_DEPTH;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int COLS = 6;
   localparam int SUM_COL = 5;
   localparam int DEPTH_W = 3;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd4;

   localparam logic KIND_TRAIN = 1'b0;
   localparam logic KIND_SCORE = 1'b1;

   localparam logic CSR_DEPTH = 1'b0;
   localparam logic CSR_IR = 1'b1;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [2:0] CODE_A = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_N = 3'd2;
   localparam logic [2:0] CODE_G = 3'd3;
   localparam logic [2:0] CODE_T = 3'd4;
   localparam logic [2:0] DIGIT_MAX = 3'd4;

   typedef logic [2:0] code_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   // context held as base-5 digits, digit 0 is the newest symbol
   typedef logic [MAX_DEPTH-1:0][2:0] ctx_type;
   typedef logic [ROW_AW-1:0] row_addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [COLS-1:0][COUNT_W-1:0] row_type;

   typedef struct packed {
      logic         kind;
      code_type     code;
      row_addr_type fwd_row;
      logic         do_rev;
      row_addr_type rev_row;
      code_type     rev_col;
   } job_type;

   typedef struct packed {
      code_type  code;
      count_type count;
      count_type total;
   } result_type;

   function automatic code_type code_of(input logic [7:0] b);
      code_type c;
      case (b)
         CHAR_A:  c = CODE_A;
         CHAR_C:  c = CODE_C;
         CHAR_G:  c = CODE_G;
         CHAR_T:  c = CODE_T;
         default: c = CODE_N;
      endcase
      return c;
   endfunction

   function automatic depth_type eff_depth(input depth_type d);
      depth_type k;
      k = d;
      if (d == '0) k = depth_type'(1);
      if (d > depth_type'(MAX_DEPTH)) k = depth_type'(MAX_DEPTH);
      return k;
   endfunction

   function automatic row_addr_type pow5(input int n);
      row_addr_type p;
      p = row_addr_type'(1);
      for (int i = 0; i < n; i++) p = row_addr_type'(p * 5);
      return p;
   endfunction

   function automatic ctx_type mask_ctx(input ctx_type c, input depth_type k);
      ctx_type m;
      m = c;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (i >= int'(k)) m[i] = '0;
      end
      return m;
   endfunction

   function automatic ctx_type fill_max(input depth_type k);
      ctx_type m;
      m = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (i < int'(k)) m[i] = DIGIT_MAX;
      end
      return m;
   endfunction

   function automatic row_addr_type row_of(input ctx_type c);
      row_addr_type acc;
      acc = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         acc = row_addr_type'(acc + row_addr_type'(c[i]) * pow5(i));
      end
      return acc;
   endfunction

   // base must already be reduced to k digits
   function automatic ctx_type fwd_next(input ctx_type base, input code_type s,
                                        input depth_type k);
      ctx_type n;
      n = '0;
      n[0] = s;
      for (int i = 1; i < MAX_DEPTH; i++) n[i] = base[i-1];
      return mask_ctx(n, k);
   endfunction

   // reverse complement: drop the low digit, complement enters at the top
   function automatic ctx_type rev_next(input ctx_type base, input code_type s,
                                        input depth_type k);
      ctx_type n;
      n = '0;
      for (int i = 0; i < MAX_DEPTH - 1; i++) begin
         if (i + 1 < int'(k)) n[i] = base[i+1];
      end
      n[k - depth_type'(1)] = DIGIT_MAX - s;
      return n;
   endfunction

   function automatic count_type bump(input count_type c);
      return (c == '1) ? c : count_type'(c + 1'b1);
   endfunction

   function automatic row_type bump_row(input row_type r, input code_type col);
      row_type n;
      n = r;
      n[col] = bump(r[col]);
      n[SUM_COL] = bump(r[SUM_COL]);
      return n;
   endfunction

endpackage

@@ src/dcc_front.sv @@
// front end: configuration registers, symbol coding and context tracking
module dcc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_kind,
   input  logic [7:0]            req_symbol_byte,
   input  logic                  req_restart,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [2:0]            csr_data,
   input  logic                  q_full,
   input  logic                  clearing,
   output logic                  job_push,
   output dcc_pkg::job_type      job
);

   dcc_pkg::depth_type depth_ff;
   logic               ir_ff;
   dcc_pkg::ctx_type   fwd_ff, fwd_in;
   dcc_pkg::ctx_type   rev_ff, rev_in;
   dcc_pkg::ctx_type   score_ff, score_in;

   dcc_pkg::depth_type k;
   dcc_pkg::code_type  s;
   dcc_pkg::ctx_type   base_f, base_r, base_s, rev_new;
   logic               accept;

   assign req_full = q_full | clearing;
   assign accept = req_push & ~req_full;
   assign job_push = accept;

   always_comb begin
      k = dcc_pkg::eff_depth(depth_ff);
      s = dcc_pkg::code_of(req_symbol_byte);
      base_f = req_restart ? '0 : dcc_pkg::mask_ctx(fwd_ff, k);
      base_r = req_restart ? dcc_pkg::fill_max(k) : dcc_pkg::mask_ctx(rev_ff, k);
      base_s = req_restart ? '0 : dcc_pkg::mask_ctx(score_ff, k);
      rev_new = dcc_pkg::rev_next(base_r, s, k);

      fwd_in = fwd_ff;
      rev_in = rev_ff;
      score_in = score_ff;

      job.kind = req_kind;
      job.code = s;
      job.do_rev = (req_kind == dcc_pkg::KIND_TRAIN) & ir_ff;
      job.rev_row = dcc_pkg::row_of(rev_new);
      job.rev_col = base_r[0];
      if (req_kind == dcc_pkg::KIND_SCORE) begin
         job.fwd_row = dcc_pkg::row_of(base_s);
         score_in = dcc_pkg::fwd_next(base_s, s, k);
      end else begin
         job.fwd_row = dcc_pkg::row_of(base_f);
         fwd_in = dcc_pkg::fwd_next(base_f, s, k);
         // restart still resets the reverse context with inverted repeats off
         if (ir_ff) rev_in = rev_new;
         else if (req_restart) rev_in = base_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= dcc_pkg::DEPTH_RESET;
         ir_ff <= 1'b0;
         fwd_ff <= '0;
         rev_ff <= dcc_pkg::fill_max(dcc_pkg::eff_depth(dcc_pkg::DEPTH_RESET));
         score_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               dcc_pkg::CSR_DEPTH: depth_ff <= csr_data;
               dcc_pkg::CSR_IR:    ir_ff <= csr_data[0];
               default:            ir_ff <= ir_ff;
            endcase
         end
         if (accept) begin
            fwd_ff <= fwd_in;
            rev_ff <= rev_in;
            score_ff <= score_in;
         end
      end
   end

endmodule

@@ src/dcc_queue.sv @@
// short job queue between the front end and the count table engine
module dcc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dcc_pkg::job_type din,
   output logic             full,
   input  logic             pop,
   output dcc_pkg::job_type dout,
   output logic             empty
);

   dcc_pkg::job_type                   entries_ff [dcc_pkg::QDEPTH];
   logic [dcc_pkg::QPTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [dcc_pkg::QPTR_W:0]           cnt_ff, cnt_in;
   logic                               do_push, do_pop;

   assign full = (cnt_ff == (dcc_pkg::QPTR_W+1)'(dcc_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign dout = entries_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push & ~do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop & ~do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ src/dcc_back.sv @@
// back end: count table memory, clearing pass, row updates and result queue
module dcc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   input  dcc_pkg::job_type           job,
   output logic                       job_pop,
   output logic                       clearing,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [2:0]                 rsp_symbol_code,
   output logic [dcc_pkg::COUNT_W-1:0] rsp_symbol_count,
   output logic [dcc_pkg::COUNT_W-1:0] rsp_row_total
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_DATA  = 2'd2;
   localparam logic [1:0] ST_WRF   = 2'd3;

   logic [1:0]            state_ff, state_in;
   dcc_pkg::row_addr_type clr_ff;
   dcc_pkg::job_type      job_ff;
   dcc_pkg::row_type      fnew_ff;
   dcc_pkg::row_type      mem_ff [dcc_pkg::ROWS];
   dcc_pkg::row_type      rdf_ff, rdr_ff;

   dcc_pkg::result_type   outq_ff [2];
   logic                  out_wr_ff, out_rd_ff;
   logic [1:0]            out_cnt_ff;

   logic                  start, out_push, out_pop;
   logic                  we;
   dcc_pkg::row_addr_type wa;
   dcc_pkg::row_type      wd, rev_new, fbase, fwd_new;
   dcc_pkg::result_type   result, head;

   assign clearing = (state_ff == ST_CLEAR);
   assign start = (state_ff == ST_IDLE) & ~job_empty & (out_cnt_ff != 2'd2);
   assign job_pop = start;
   assign out_push = (state_ff == ST_DATA);
   assign out_pop = rsp_pop & (out_cnt_ff != 2'd0);

   assign head = outq_ff[out_rd_ff];
   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_symbol_code = head.code;
   assign rsp_symbol_count = head.count;
   assign rsp_row_total = head.total;

   always_comb begin
      rev_new = dcc_pkg::bump_row(rdr_ff, job_ff.rev_col);
      // same row: the forward bump lands on top of the reverse bump
      fbase = (job_ff.do_rev && job_ff.rev_row == job_ff.fwd_row) ? rev_new : rdf_ff;
      fwd_new = dcc_pkg::bump_row(fbase, job_ff.code);

      result.code = job_ff.code;
      result.count = rdf_ff[job_ff.code];
      result.total = rdf_ff[dcc_pkg::SUM_COL];

      we = 1'b0;
      wa = job_ff.fwd_row;
      wd = fwd_new;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
            wd = '0;
            if (clr_ff == dcc_pkg::row_addr_type'(dcc_pkg::ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DATA;
         end
         ST_DATA: begin
            state_in = ST_IDLE;
            if (job_ff.kind == dcc_pkg::KIND_TRAIN) begin
               we = 1'b1;
               if (job_ff.do_rev) begin
                  wa = job_ff.rev_row;
                  wd = rev_new;
                  state_in = ST_WRF;
               end
            end
         end
         ST_WRF: begin
            we = 1'b1;
            wa = job_ff.fwd_row;
            wd = fnew_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem_ff[wa] <= wd;
      if (start) begin
         rdf_ff <= mem_ff[job.fwd_row];
         rdr_ff <= mem_ff[job.rev_row];
      end
   end

   always_ff @(posedge clock) begin
      if (start) job_ff <= job;
      if (state_ff == ST_DATA) fnew_ff <= fwd_new;
      if (out_push) outq_ff[out_wr_ff] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_wr_ff <= 1'b0;
         out_rd_ff <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (out_push) out_wr_ff <= ~out_wr_ff;
         if (out_pop) out_rd_ff <= ~out_rd_ff;
         if (out_push & ~out_pop) out_cnt_ff <= out_cnt_ff + 1'b1;
         if (out_pop & ~out_push) out_cnt_ff <= out_cnt_ff - 1'b1;
      end
   end

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_cnt_ff != 2'd2)
      else $error("result pushed into a full queue");

   a_wrf_after_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRF |-> $past(state_ff) == ST_DATA)
      else $error("second write without a preceding read");

   a_data_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> $past(job_pop))
      else $error("row data used without a job taken");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !job_pop)
      else $error("job taken during clearing pass");

endmodule

@@ src/dna_context_count_model_top.sv @@
// top level of the dna context count model: front end, job queue, count table engine
// an accepted item enters the job queue; its rows are read, then its result is queued
// score items and train items without inverted repeats pass the idle and data states;
// train items with inverted repeats also a second write state, for the read-modify-write
// reset: synchronous; afterwards a clearing pass zeroes the 15625 table rows, one row per
// cycle, and req_full stays high throughout the pass (configuration writes still taken)
module dna_context_count_model_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_kind,
   input  logic [7:0]                  req_symbol_byte,
   input  logic                        req_restart,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [2:0]                  rsp_symbol_code,
   output logic [dcc_pkg::COUNT_W-1:0] rsp_symbol_count,
   output logic [dcc_pkg::COUNT_W-1:0] rsp_row_total,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [2:0]                  csr_data
);

   logic             q_full, q_empty, job_push, job_pop, clearing;
   dcc_pkg::job_type job_in, job_out;

   dcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_symbol_byte (req_symbol_byte),
      .req_restart     (req_restart),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .clearing        (clearing),
      .job_push        (job_push),
      .job             (job_in)
   );

   dcc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .full  (q_full),
      .pop   (job_pop),
      .dout  (job_out),
      .empty (q_empty)
   );

   dcc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (q_empty),
      .job              (job_out),
      .job_pop          (job_pop),
      .clearing         (clearing),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_symbol_code  (rsp_symbol_code),
      .rsp_symbol_count (rsp_symbol_count),
      .rsp_row_total    (rsp_row_total)
   );

endmodule

@@ tb/dna_context_count_model_top_tb.sv @@
// testbench of the dna context count model: queue driver, result checker and count predictor
`timescale 1ns / 1ps

module dna_context_count_model_top_tb;

   localparam int STALL_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic       kind;
      logic [7:0] symbol_byte;
      logic       restart;
   } seq_item_type;

   typedef struct packed {
      dcc_pkg::code_type  code;
      dcc_pkg::count_type count;
      dcc_pkg::count_type total;
   } count_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic             req_kind = dcc_pkg::KIND_TRAIN;
   logic [7:0]       req_symbol_byte = 8'h00;
   logic             req_restart = 1'b0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [2:0]       rsp_symbol_code;
   logic [dcc_pkg::COUNT_W-1:0] rsp_symbol_count;
   logic [dcc_pkg::COUNT_W-1:0] rsp_row_total;
   logic             csr_write = 1'b0;
   logic             csr_index = dcc_pkg::CSR_DEPTH;
   logic [2:0]       csr_data = 3'd0;

   seq_item_type     pending_items[$];
   count_result_type expected_counts[$];
   logic [7:0]       last_train_bases[$];

   // predictor state
   int unsigned count_table [0:dcc_pkg::ROWS*dcc_pkg::COLS-1];
   int unsigned fwd_ctx;
   int unsigned rev_ctx;
   int unsigned score_ctx;
   logic [2:0]  depth_cfg;
   logic        ir_cfg;

   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int idle_cycles = 0;

   wire item_taken = req_push && !req_full;
   wire result_taken = rsp_pop && !rsp_empty;

   dna_context_count_model_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_symbol_byte  (req_symbol_byte),
      .req_restart      (req_restart),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_symbol_code  (rsp_symbol_code),
      .rsp_symbol_count (rsp_symbol_count),
      .rsp_row_total    (rsp_row_total),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic dcc_pkg::code_type symbol_code_of(input logic [7:0] b);
      case (b)
         dcc_pkg::CHAR_A: return dcc_pkg::CODE_A;
         dcc_pkg::CHAR_C: return dcc_pkg::CODE_C;
         dcc_pkg::CHAR_G: return dcc_pkg::CODE_G;
         dcc_pkg::CHAR_T: return dcc_pkg::CODE_T;
         default:         return dcc_pkg::CODE_N;
      endcase
   endfunction

   // number of rows spanned by a context at the given depth setting
   function automatic int unsigned ctx_span(input logic [2:0] d);
      int k;
      int unsigned p;
      k = (d == 3'd0) ? 1 :
          ((int'(d) > dcc_pkg::MAX_DEPTH) ? dcc_pkg::MAX_DEPTH : int'(d));
      p = 1;
      for (int i = 0; i < k; i++) p = p * 5;
      return p;
   endfunction

   function automatic void bump_count(input int unsigned idx);
      if (count_table[idx] != 32'hFFFF_FFFF) count_table[idx] = count_table[idx] + 1;
   endfunction

   function automatic count_result_type predict_count(input seq_item_type it);
      int unsigned p, s, c, r, t, row;
      count_result_type res;
      p = ctx_span(depth_cfg);
      s = symbol_code_of(it.symbol_byte);
      if (it.kind == dcc_pkg::KIND_SCORE) begin
         if (it.restart) score_ctx = 0;
         c = score_ctx % p;
         score_ctx = (c * 5 + s) % p;
      end else begin
         if (it.restart) begin
            fwd_ctx = 0;
            rev_ctx = p - 1;
         end
         c = fwd_ctx % p;
      end
      res.code = dcc_pkg::code_type'(s);
      res.count = count_table[c * dcc_pkg::COLS + s];
      res.total = count_table[c * dcc_pkg::COLS + dcc_pkg::SUM_COL];
      if (it.kind == dcc_pkg::KIND_TRAIN) begin
         // complement enters at the top digit, the low digit drops out
         if (ir_cfg) begin
            r = rev_ctx % p;
            t = r + (4 - s) * p;
            row = t / 5;
            bump_count(row * dcc_pkg::COLS + t % 5);
            bump_count(row * dcc_pkg::COLS + dcc_pkg::SUM_COL);
            rev_ctx = row;
         end
         bump_count(c * dcc_pkg::COLS + s);
         bump_count(c * dcc_pkg::COLS + dcc_pkg::SUM_COL);
         fwd_ctx = (c * 5 + s) % p;
      end
      return res;
   endfunction

   always @(posedge clock) begin : drive_items
      logic         push_next;
      seq_item_type next_item;
      push_next = req_push;
      next_item = {req_kind, req_symbol_byte, req_restart};
      if (reset) begin
         push_next = 1'b0;
      end else begin
         if (item_taken) begin
            expected_counts = {expected_counts, predict_count(next_item)};
            push_next = 1'b0;
         end
         if (!push_next && pending_items.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            next_item = pending_items.pop_front();
            push_next = 1'b1;
         end
      end
      req_push <= push_next;
      req_kind <= next_item.kind;
      req_symbol_byte <= next_item.symbol_byte;
      req_restart <= next_item.restart;
   end

   always @(posedge clock) begin : check_results
      count_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (result_taken) begin
            if (expected_counts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result with no item pending: code %0d count %0d total %0d",
                           rsp_symbol_code, rsp_symbol_count, rsp_row_total);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_symbol_code !== want.code || rsp_symbol_count !== want.count ||
                   rsp_row_total !== want.total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected code %0d count %0d total %0d, got %0d %0d %0d",
                              want.code, want.count, want.total,
                              rsp_symbol_code, rsp_symbol_count, rsp_row_total);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // covers the clearing pass after reset with plenty of margin
   always @(posedge clock) begin : watchdog
      if (reset || item_taken || result_taken) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(input logic kind, input logic [7:0] b, input logic restart);
      seq_item_type it;
      it.kind = kind;
      it.symbol_byte = b;
      it.restart = restart;
      pending_items = {pending_items, it};
   endtask

   function automatic logic [7:0] random_base();
      int pick;
      pick = $urandom_range(19);
      if (pick == 19) return 8'($urandom_range(255));
      if (pick == 18) return "N";
      case (pick % 4)
         0:       return dcc_pkg::CHAR_A;
         1:       return dcc_pkg::CHAR_C;
         2:       return dcc_pkg::CHAR_G;
         default: return dcc_pkg::CHAR_T;
      endcase
   endfunction

   // mostly restarted runs of bases, score runs often replay the last trained run
   task automatic add_random_items(input int n);
      int added, len;
      logic is_score, restart_first;
      logic [7:0] b;
      added = 0;
      while (added < n) begin
         is_score = 1'($urandom_range(1));
         restart_first = ($urandom_range(3) != 0);
         if ($urandom_range(9) == 0) begin
            len = $urandom_range(3, 12);
            if (len > n - added) len = n - added;
            for (int i = 0; i < len; i++)
               add_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (is_score && $urandom_range(1) && last_train_bases.size() > 0) begin
            len = last_train_bases.size();
            if (len > n - added) len = n - added;
            for (int i = 0; i < len; i++)
               add_item(dcc_pkg::KIND_SCORE, last_train_bases[i], restart_first && i == 0);
         end else begin
            len = $urandom_range(3, 30);
            if (len > n - added) len = n - added;
            if (!is_score) last_train_bases.delete();
            for (int i = 0; i < len; i++) begin
               b = random_base();
               if (!is_score) last_train_bases = {last_train_bases, b};
               add_item(is_score, b, restart_first && i == 0);
            end
         end
         added += len;
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_push || expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [2:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      if (index == dcc_pkg::CSR_DEPTH) depth_cfg = data;
      else ir_cfg = data[0];
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [2:0] depth, input logic ir, input int idle_pct,
                            input int stall_pct, input int n);
      wait_drained();
      write_csr(dcc_pkg::CSR_DEPTH, depth);
      write_csr(dcc_pkg::CSR_IR, {2'($urandom_range(3)), ir});
      csr_write <= 1'b0;
      sender_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      add_random_items(n);
   endtask

   initial begin
      depth_cfg = dcc_pkg::DEPTH_RESET;
      ir_cfg = 1'b0;
      fwd_ctx = 0;
      score_ctx = 0;
      rev_ctx = ctx_span(dcc_pkg::DEPTH_RESET) - 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all codes, byte extremes, restart on both kinds
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_A, 1'b1);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_C, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_G, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_T, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, 8'h00, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, 8'hFF, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, "a", 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_A, 1'b1);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_C, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_G, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_A, 1'b1);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_C, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_G, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, 8'hFF, 1'b0);

      // order one with inverted repeats: forward and reverse rows collide
      wait_drained();
      write_csr(dcc_pkg::CSR_DEPTH, 3'd1);
      write_csr(dcc_pkg::CSR_IR, 3'd1);
      csr_write <= 1'b0;
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_A, 1'b1);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_T, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_G, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_C, 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, "N", 1'b0);
      add_item(dcc_pkg::KIND_TRAIN, dcc_pkg::CHAR_A, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_A, 1'b1);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_T, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, 8'h00, 1'b0);
      add_item(dcc_pkg::KIND_SCORE, dcc_pkg::CHAR_G, 1'b0);

      run_phase(3'd1, 1'b1, 0, 0, 120);
      run_phase(3'd6, 1'b0, 53, 0, 120);
      run_phase(3'd3, 1'b1, 0, 53, 120);
      run_phase(3'd6, 1'b1, 32, 32, 120);
      run_phase(3'd0, 1'b1, 0, 0, 120);
      run_phase(3'd7, 1'b0, 53, 0, 120);
      run_phase(3'd2, 1'b1, 0, 53, 120);
      run_phase(3'd5, 1'b0, 32, 32, 120);
      run_phase(3'd4, 1'b1, 32, 32, 120);

      wait_drained();
      if (fail_count == 0 && expected_counts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/dcc_pkg.sv
src/dcc_front.sv
src/dcc_queue.sv
src/dcc_back.sv
src/dna_context_count_model_top.sv
tb/dna_context_count_model_top_tb.sv
